/* design/pfr_pkg.sv */
package pfr_pkg;

  localparam logic [7:0] STOP_BYTE    = 8'h16;
  localparam logic [7:0] DEFAULT_TYPE = 8'h68;
  localparam logic [4:0] DEFAULT_CAP  = 5'd24;
  localparam logic [7:0] SHORT_LIMIT  = 8'd6;
  localparam logic [7:0] CODE_IDX     = 8'd1;
  localparam logic [7:0] PAYLOAD_IDX  = 8'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_LONG    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic CFG_FRAME_TYPE = 1'b0;
  localparam logic CFG_CAPACITY   = 1'b1;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_UNKNOWN,
    EM_SHORT,
    EM_BAD,
    EM_LONG,
    EM_PAYLOAD
  } emit_t;

  typedef struct packed {
    logic  ld_len1;
    logic  clr_frame;
    logic  body_step;
    logic  chk_step;
    logic  rd_start;
    logic  rd_next;
    emit_t emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic type_match;
    logic len_match;
    logic len_zero;
    logic body_done;
    logic short_frame;
    logic chk_good;
    logic too_long;
    logic drain_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

/* design/pfr_ram.sv */
module pfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 24
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/pfr_dp.sv */
module pfr_dp
  import pfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ctrl_cmd_t  cmd,
  output ctrl_sts_t  sts,
  input  logic [7:0] in_rx_byte,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic       out_has_data,
  output logic [7:0] out_message_code,
  output logic [4:0] out_payload_len,
  output logic [1:0] out_frame_status,
  output logic       out_last
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]    frame_type_r, frame_type_nxt;
  logic [4:0]    cap_r, cap_nxt;
  logic [7:0]    first_len_r, first_len_nxt;
  logic [7:0]    byte_idx_r, byte_idx_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [7:0]    code_r, code_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [7:0] data_r, data_nxt;
  logic       has_r, has_nxt;
  logic [7:0] mcode_r, mcode_nxt;
  logic [4:0] plen_r, plen_nxt;
  logic [1:0] status_r, status_nxt;
  logic       last_r, last_nxt;

  logic [7:0] pos;
  logic       wr_en;
  logic [7:0] rd_data;
  logic [7:0] ulen;
  logic [6:0] eff_cap;
  logic       load;

  pfr_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(pos[AW-1:0]),
    .wr_data(in_rx_byte),
    .rd_addr(rd_idx_r),
    .rd_data(rd_data)
  );

  assign pos     = byte_idx_r - PAYLOAD_IDX;
  assign wr_en   = cmd.body_step && (byte_idx_r >= PAYLOAD_IDX) && (pos < 8'(MAX_PAYLOAD));
  assign ulen    = first_len_r - SHORT_LIMIT;
  assign eff_cap = ({2'b00, cap_r} > 7'(MAX_PAYLOAD)) ? 7'(MAX_PAYLOAD) : {2'b00, cap_r};
  assign load    = (cmd.emit != EM_NONE);

  always_comb begin
    sts.type_match  = (in_rx_byte == frame_type_r);
    sts.len_match   = (in_rx_byte == first_len_r);
    sts.len_zero    = (first_len_r == 8'd0);
    sts.body_done   = ((byte_idx_r + 8'd1) == first_len_r);
    sts.short_frame = (first_len_r <= SHORT_LIMIT);
    sts.chk_good    = (sum_r == 8'd0) && (in_rx_byte == STOP_BYTE);
    sts.too_long    = (ulen > {1'b0, eff_cap});
    sts.drain_last  = ((8'(rd_idx_r) + 8'd1) == ulen);
    sts.out_free    = !out_valid_r || !out_stall;
  end

  always_comb begin
    frame_type_nxt = frame_type_r;
    cap_nxt        = cap_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_TYPE: frame_type_nxt = cfg_data;
        CFG_CAPACITY:   cap_nxt        = cfg_data[4:0];
        default:        ;
      endcase
    end

    first_len_nxt = cmd.ld_len1 ? in_rx_byte : first_len_r;
    byte_idx_nxt  = byte_idx_r;
    sum_nxt       = sum_r;
    code_nxt      = code_r;
    if (cmd.clr_frame) begin
      byte_idx_nxt = 8'd0;
      sum_nxt      = 8'd0;
      code_nxt     = 8'd0;
    end else if (cmd.body_step) begin
      byte_idx_nxt = byte_idx_r + 8'd1;
      sum_nxt      = sum_r + in_rx_byte;
      if (byte_idx_r == CODE_IDX) begin
        code_nxt = in_rx_byte;
      end
    end else if (cmd.chk_step) begin
      sum_nxt = sum_r - in_rx_byte;
    end

    priority if (cmd.rd_start) begin
      rd_idx_nxt = '0;
    end else if (cmd.rd_next) begin
      rd_idx_nxt = rd_idx_r + 1'b1;
    end else begin
      rd_idx_nxt = rd_idx_r;
    end
  end

  // output register: every non-payload report is a single transaction with last set
  always_comb begin
    data_nxt   = data_r;
    has_nxt    = has_r;
    mcode_nxt  = mcode_r;
    plen_nxt   = plen_r;
    status_nxt = status_r;
    last_nxt   = last_r;
    if (load) begin
      data_nxt   = 8'd0;
      has_nxt    = 1'b0;
      mcode_nxt  = 8'd0;
      plen_nxt   = 5'd0;
      last_nxt   = 1'b1;
      status_nxt = ST_OK;
      unique case (cmd.emit)
        EM_UNKNOWN: status_nxt = ST_UNKNOWN;
        EM_BAD:     status_nxt = ST_BAD;
        EM_LONG:    status_nxt = ST_LONG;
        EM_PAYLOAD: begin
          data_nxt  = rd_data;
          has_nxt   = 1'b1;
          mcode_nxt = code_r;
          plen_nxt  = ulen[4:0];
          last_nxt  = sts.drain_last;
        end
        default:    status_nxt = ST_OK;
      endcase
    end
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_type_r <= DEFAULT_TYPE;
      cap_r        <= DEFAULT_CAP;
      first_len_r  <= 8'd0;
      byte_idx_r   <= 8'd0;
      sum_r        <= 8'd0;
      code_r       <= 8'd0;
      rd_idx_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      frame_type_r <= frame_type_nxt;
      cap_r        <= cap_nxt;
      first_len_r  <= first_len_nxt;
      byte_idx_r   <= byte_idx_nxt;
      sum_r        <= sum_nxt;
      code_r       <= code_nxt;
      rd_idx_r     <= rd_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r   <= data_nxt;
    has_r    <= has_nxt;
    mcode_r  <= mcode_nxt;
    plen_r   <= plen_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = data_r;
  assign out_has_data     = has_r;
  assign out_message_code = mcode_r;
  assign out_payload_len  = plen_r;
  assign out_frame_status = status_r;
  assign out_last         = last_r;

endmodule

/* design/pfr_ctrl.sv */
module pfr_ctrl
  import pfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_HUNT     = 9'b000000001,
    S_LEN1     = 9'b000000010,
    S_LEN2     = 9'b000000100,
    S_TYPE2    = 9'b000001000,
    S_BODY     = 9'b000010000,
    S_CHK      = 9'b000100000,
    S_STOP     = 9'b001000000,
    S_DRAIN_RD = 9'b010000000,
    S_DRAIN_WR = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   draining;
  logic   in_fire;

  assign draining = (state_r == S_DRAIN_RD) || (state_r == S_DRAIN_WR);
  assign in_stall = draining || !sts.out_free;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    cmd.ld_len1   = 1'b0;
    cmd.clr_frame = 1'b0;
    cmd.body_step = 1'b0;
    cmd.chk_step  = 1'b0;
    cmd.rd_start  = 1'b0;
    cmd.rd_next   = 1'b0;
    cmd.emit      = EM_NONE;
    unique case (state_r)
      S_HUNT: begin
        if (in_fire) begin
          if (sts.type_match) begin
            state_nxt = S_LEN1;
          end else begin
            cmd.emit = EM_UNKNOWN;
          end
        end
      end
      S_LEN1: begin
        if (in_fire) begin
          cmd.ld_len1 = 1'b1;
          state_nxt   = S_LEN2;
        end
      end
      S_LEN2: begin
        if (in_fire) begin
          if (sts.len_match) begin
            state_nxt = S_TYPE2;
          end else begin
            cmd.emit  = EM_UNKNOWN;
            state_nxt = S_HUNT;
          end
        end
      end
      S_TYPE2: begin
        if (in_fire) begin
          cmd.clr_frame = 1'b1;
          state_nxt     = sts.len_zero ? S_CHK : S_BODY;
        end
      end
      S_BODY: begin
        if (in_fire) begin
          cmd.body_step = 1'b1;
          if (sts.body_done) begin
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (in_fire) begin
          cmd.chk_step = 1'b1;
          state_nxt    = S_STOP;
        end
      end
      S_STOP: begin
        if (in_fire) begin
          state_nxt = S_HUNT;
          priority if (sts.short_frame) begin
            cmd.emit = EM_SHORT;
          end else if (!sts.chk_good) begin
            cmd.emit = EM_BAD;
          end else if (sts.too_long) begin
            cmd.emit = EM_LONG;
          end else begin
            cmd.rd_start = 1'b1;
            state_nxt    = S_DRAIN_RD;
          end
        end
      end
      S_DRAIN_RD: state_nxt = S_DRAIN_WR;
      S_DRAIN_WR: begin
        if (sts.out_free) begin
          cmd.emit = EM_PAYLOAD;
          if (sts.drain_last) begin
            state_nxt = S_HUNT;
          end else begin
            cmd.rd_next = 1'b1;
            state_nxt   = S_DRAIN_RD;
          end
        end
      end
      default: state_nxt = S_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/pei_frame_receiver.sv */
// A report caused by a byte is loaded into the output register at the edge that takes the
// byte. Throughput: one byte per cycle while a frame is received and the output is not stalled.
// A good frame's payload bytes are then read from the store one at a time, each passing through
// S_DRAIN_RD and S_DRAIN_WR (store read is registered) and loaded once the output is free; no
// input is taken during the drain, nor while a result waits under stall.
// Reset (rst_n, synchronous, active low) returns to hunting, empties the output register and
// restores frame_type 0x68 and payload_capacity 24.
module pei_frame_receiver
  import pfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic       out_has_data,
  output logic [7:0] out_message_code,
  output logic [4:0] out_payload_len,
  output logic [1:0] out_frame_status,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  pfr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  pfr_dp #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_rx_byte      (in_rx_byte),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_payload_byte(out_payload_byte),
    .out_has_data    (out_has_data),
    .out_message_code(out_message_code),
    .out_payload_len (out_payload_len),
    .out_frame_status(out_frame_status),
    .out_last        (out_last)
  );

  // a new result never overwrites one still held under stall
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit != EM_NONE) |-> sts.out_free)
    else $error("result loaded over a pending transaction");

  // body bytes only advance on an accepted transaction
  a_body_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.body_step || cmd.chk_step || cmd.ld_len1) |-> (in_valid && !in_stall))
    else $error("frame state moved without an input transaction");

  // error reports are single transactions
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_frame_status != ST_OK)) |-> (out_last && !out_has_data))
    else $error("error report not a single last transaction");

endmodule

/* bench/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfr_pkg::*;

  localparam int PAY_MAX        = 24;
  localparam int RX_HOLD_CYCLES = 500;
  localparam int MAX_PRINTS     = 40;

  typedef enum logic [2:0] {
    RX_HUNT, RX_LEN_A, RX_LEN_B, RX_TYPE_B, RX_BODY, RX_CSUM, RX_STOP
  } rx_phase_t;

  typedef enum int {FAULT_NONE, FAULT_LEN, FAULT_SUM, FAULT_STOP} fault_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic [7:0] code;
    logic [4:0] len;
    logic [1:0] status;
    logic       last;
  } report_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic [7:0] out_payload_byte;
  logic       out_has_data;
  logic [7:0] out_message_code;
  logic [4:0] out_payload_len;
  logic [1:0] out_frame_status;
  logic       out_last;
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  logic       cfg_index  = 1'b0;
  logic [7:0] cfg_data   = 8'h00;

  always #5 clk = ~clk;

  pei_frame_receiver #(.MAX_PAYLOAD(PAY_MAX)) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_has_data     (out_has_data),
    .out_message_code (out_message_code),
    .out_payload_len  (out_payload_len),
    .out_frame_status (out_frame_status),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // receiver copy: configuration and frame state
  logic [7:0] ftype_q = DEFAULT_TYPE;
  logic [4:0] cap_q   = DEFAULT_CAP;
  rx_phase_t  rx_ph   = RX_HUNT;
  logic [7:0] len_q   = 8'h00;
  logic [7:0] pos_q   = 8'h00;
  logic [7:0] sum_q   = 8'h00;
  logic [7:0] code_q  = 8'h00;
  logic [7:0] pay_q [PAY_MAX];

  report_t     expected_reports [$];
  logic [7:0]  pending_bytes [$];
  int unsigned bytes_queued = 0;
  int unsigned err_cnt      = 0;
  int unsigned tx_gap       = 0;
  int unsigned rx_wait      = 0;
  logic        tx_burst     = 1'b0;
  logic        rx_burst     = 1'b0;
  logic        rx_hold      = 1'b0;
  event        hold_go;

  function automatic report_t status_only(input logic [1:0] st);
    report_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic track_frame_byte(input logic [7:0] b);
    report_t    r;
    logic [7:0] ulen;
    logic [7:0] lim;
    case (rx_ph)
      RX_HUNT: begin
        if (b == ftype_q) rx_ph = RX_LEN_A;
        else expected_reports.push_back(status_only(ST_UNKNOWN));
      end
      RX_LEN_A: begin
        len_q = b;
        rx_ph = RX_LEN_B;
      end
      RX_LEN_B: begin
        if (b != len_q) begin
          expected_reports.push_back(status_only(ST_UNKNOWN));
          rx_ph = RX_HUNT;
        end else begin
          rx_ph = RX_TYPE_B;
        end
      end
      RX_TYPE_B: begin
        // second type byte is not checked
        pos_q = 8'h00;
        sum_q = 8'h00;
        code_q = 8'h00;
        rx_ph = (len_q != 8'h00) ? RX_BODY : RX_CSUM;
      end
      RX_BODY: begin
        sum_q = sum_q + b;
        if (pos_q == CODE_IDX) code_q = b;
        if (pos_q >= PAYLOAD_IDX && (pos_q - PAYLOAD_IDX) < PAY_MAX)
          pay_q[pos_q - PAYLOAD_IDX] = b;
        pos_q = pos_q + 8'd1;
        if (pos_q == len_q) rx_ph = RX_CSUM;
      end
      RX_CSUM: begin
        sum_q = sum_q - b;
        rx_ph = RX_STOP;
      end
      RX_STOP: begin
        rx_ph = RX_HUNT;
        lim = (cap_q > PAY_MAX) ? 8'(PAY_MAX) : 8'(cap_q);
        if (len_q <= SHORT_LIMIT) begin
          expected_reports.push_back(status_only(ST_OK));
        end else if (sum_q != 8'h00 || b != STOP_BYTE) begin
          expected_reports.push_back(status_only(ST_BAD));
        end else begin
          ulen = len_q - SHORT_LIMIT;
          if (ulen > lim) begin
            expected_reports.push_back(status_only(ST_LONG));
          end else begin
            for (int i = 0; i < ulen; i++) begin
              r.data = pay_q[i];
              r.has = 1'b1;
              r.code = code_q;
              r.len = ulen[4:0];
              r.status = ST_OK;
              r.last = (i == ulen - 1);
              expected_reports.push_back(r);
            end
          end
        end
      end
      default: rx_ph = RX_HUNT;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) $display("mismatch at %0t: %0s", $realtime, msg);
  endtask

  // driver: one byte per transaction, random gap drawn after each one
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tx_gap = tx_burst ? 0 : $urandom_range(0, 9);
      if (!in_valid || !in_stall) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_rx_byte <= pending_bytes.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: results are checked before the byte of this edge is tracked,
  // so ordering within the edge is fixed
  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.data = out_payload_byte;
        got.has = out_has_data;
        got.code = out_message_code;
        got.len = out_payload_len;
        got.status = out_frame_status;
        got.last = out_last;
        if (expected_reports.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", got));
        end else begin
          want = expected_reports.pop_front();
          if (got !== want)
            report_mismatch($sformatf(
              "data %h/%h has %b/%b code %h/%h len %0d/%0d status %0d/%0d last %b/%b",
              got.data, want.data, got.has, want.has, got.code, want.code,
              got.len, want.len, got.status, want.status, got.last, want.last));
        end
        rx_wait = rx_burst ? 0 : $urandom_range(0, 9);
      end else if (out_valid && rx_wait != 0) begin
        rx_wait--;
      end
      if (in_valid && !in_stall) begin
        track_frame_byte(in_rx_byte);
      end
      out_stall <= rx_hold || (rx_wait != 0);
    end
  end

  // long receiver hold-off so the output backs up and the input stalls
  initial begin
    @(hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic offer(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_frame(input int unsigned flen, input fault_t fault);
    logic [7:0] sum;
    logic [7:0] v;
    sum = 8'h00;
    offer(ftype_q);
    offer(flen[7:0]);
    if (fault == FAULT_LEN) begin
      offer(flen[7:0] ^ 8'($urandom_range(1, 255)));
    end else begin
      offer(flen[7:0]);
      offer(8'($urandom));
      for (int i = 0; i < flen; i++) begin
        v = 8'($urandom);
        sum = sum + v;
        offer(v);
      end
      if (fault == FAULT_SUM) sum = sum + 8'($urandom_range(1, 255));
      offer(sum);
      offer((fault == FAULT_STOP) ? (STOP_BYTE ^ 8'($urandom_range(1, 255))) : STOP_BYTE);
    end
  endtask

  task automatic queue_random_frame();
    int unsigned pick;
    int unsigned flen;
    fault_t      f;
    pick = $urandom_range(0, 99);
    if (pick < 15) flen = $urandom_range(0, 6);
    else if (pick < 80) flen = $urandom_range(7, 14);
    else if (pick < 98) flen = $urandom_range(15, 30);
    else flen = $urandom_range(31, 40);
    pick = $urandom_range(0, 99);
    f = (pick < 72) ? FAULT_NONE : (pick < 82) ? FAULT_SUM :
        (pick < 90) ? FAULT_STOP : FAULT_LEN;
    // stray line noise between frames
    if ($urandom_range(0, 9) == 0) offer(8'($urandom));
    queue_frame(flen, f);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_reports.size() != 0);
    // a trailing byte that gives no report may still be in flight
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_FRAME_TYPE) ftype_q = val;
    else cap_q = val[4:0];
    @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] ft, input logic [7:0] cap);
    if ($urandom_range(0, 1) == 0) begin
      write_reg(CFG_FRAME_TYPE, ft);
      write_reg(CFG_CAPACITY, cap);
    end else begin
      write_reg(CFG_CAPACITY, cap);
      write_reg(CFG_FRAME_TYPE, ft);
    end
  endtask

  task automatic run_phase(input int unsigned budget);
    int unsigned start;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      tx_burst <= ($urandom_range(0, 3) == 0);
      rx_burst <= ($urandom_range(0, 3) == 0);
      queue_random_frame();
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // wrong start bytes, length mismatch, empty short frame, smallest payload frame
    offer(8'h00);
    offer(8'hFF);
    queue_frame(5, FAULT_LEN);
    queue_frame(0, FAULT_NONE);
    queue_frame(7, FAULT_NONE);
    wait_drained();

    // full payload while the receiver holds off
    queue_frame(30, FAULT_NONE);
    -> hold_go;
    run_phase(4);
    wait_drained();

    set_config(8'h00, 8'd0);
    queue_frame(7, FAULT_NONE);
    wait_drained();

    // capacity above the store size acts as the store size
    set_config(8'hFF, {3'($urandom), 5'd31});
    queue_frame(31, FAULT_NONE);
    run_phase(4);
    wait_drained();

    set_config(8'($urandom), 8'($urandom_range(0, 24)));
    run_phase(4);
    wait_drained();

    set_config(DEFAULT_TYPE, {3'($urandom), 5'd6});
    run_phase(4);

    wait_drained();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end

endmodule
